/* rtl/ledcrd_pkg.sv */
// ----------------------------------------------------------------------------
// ledcrd_pkg
// Shared types and constants for the LED current ramp and duty block.
// ----------------------------------------------------------------------------
package ledcrd_pkg;

    // field widths
    localparam int MA_W     = 15;
    localparam int SHUNT_W  = 16;
    localparam int DIVR_W   = 16;
    localparam int OFF_W    = 8;
    localparam int VMV_W    = 13;
    localparam int DUTY_W   = 14;

    // stream and config port widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // ramp constants
    localparam logic [15:0] FAST_JUMP_MA   = 16'd6000;
    localparam logic [15:0] RAMP_START_MA  = 16'd1500;
    localparam logic [15:0] STEP_STROBE_MA = 16'd3000;
    localparam logic [15:0] STEP_SOS_MA    = 16'd500;
    localparam logic [15:0] STEP_OTHER_MA  = 16'd20;

    // floor(x / 205) = (x * RECIP_205) >> RECIP_SHIFT for x < 2^15
    localparam logic [15:0] RECIP_205   = 16'd40921;
    localparam int          RECIP_SHIFT = 23;

    // duty scaling: denominator carries divider * supply_mv * 1000
    localparam logic [15:0]       DEN_SCALE = 16'd1000;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 14'd10000;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_STEPLESS = 2'd1,
        MODE_BLINK    = 2'd2,
        MODE_BEACON   = 2'd3
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TURBO_LIMIT = 3'd0,
        REG_AUX_MAX     = 3'd1,
        REG_MAIN_SHUNT  = 3'd2,
        REG_AUX_SHUNT   = 3'd3,
        REG_DIVIDER     = 3'd4
    } t_reg_idx;

    // request to the duty engine, latched on start
    typedef struct packed {
        logic [MA_W-1:0]    ma;
        logic [SHUNT_W-1:0] shunt;
        t_mode              mode;
        logic [OFF_W-1:0]   off;
        logic [VMV_W-1:0]   vmv;
        logic [DIVR_W-1:0]  divr;
    } t_duty_req;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] duty;
    } t_duty_rsp;

endpackage

/* rtl/ledcrd_duty.sv */
// ----------------------------------------------------------------------------
// ledcrd_duty
// Duty engine: one shared 31x16 multiplier builds numerator and denominator,
// then a 14-step restoring divider produces the capped duty.
// ----------------------------------------------------------------------------
module ledcrd_duty (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ledcrd_pkg::t_duty_req i_req,
    output ledcrd_pkg::t_duty_rsp o_rsp
);

    typedef enum logic [8:0] {
        D_IDLE  = 9'b000000001,
        D_Q205  = 9'b000000010,
        D_FACT  = 9'b000000100,
        D_MNUM  = 9'b000001000,
        D_MDEN1 = 9'b000010000,
        D_MDEN2 = 9'b000100000,
        D_CHK   = 9'b001000000,
        D_DIV   = 9'b010000000,
        D_DONE  = 9'b100000000
    } t_dstate;

    t_dstate r_state, n_state;

    logic [ledcrd_pkg::MA_W-1:0]    r_ma;
    logic [ledcrd_pkg::SHUNT_W-1:0] r_shunt;
    ledcrd_pkg::t_mode              r_mode;
    logic [ledcrd_pkg::OFF_W-1:0]   r_off;
    logic [ledcrd_pkg::VMV_W-1:0]   r_vmv;
    logic [ledcrd_pkg::DIVR_W-1:0]  r_divr;
    logic [6:0]                     r_fac;
    logic [46:0]                    r_prod;
    logic [53:0]                    r_num;
    logic [53:0]                    r_rem;
    logic [51:0]                    r_dsh;
    logic [ledcrd_pkg::DUTY_W-1:0]  r_quo;
    logic [3:0]                     r_cnt;
    logic [ledcrd_pkg::DUTY_W-1:0]  r_duty;

    logic [30:0] w_mul_a;
    logic [15:0] w_mul_b;
    logic [46:0] w_prod;
    logic [7:0]  w_q205;
    logic [7:0]  w_fac;
    logic        w_fac_pos;
    logic [38:0] w_den;
    logic        w_rem_ge;
    logic [ledcrd_pkg::DUTY_W-1:0] w_quo_next;

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            D_Q205: begin
                w_mul_a = {16'b0, r_ma};
                w_mul_b = ledcrd_pkg::RECIP_205;
            end
            D_FACT: begin
                w_mul_a = {16'b0, r_ma};
                w_mul_b = r_shunt;
            end
            D_MNUM: begin
                w_mul_a = r_prod[30:0];
                w_mul_b = {9'b0, r_fac};
            end
            D_MDEN1: begin
                w_mul_a = {15'b0, r_divr};
                w_mul_b = {3'b0, r_vmv};
            end
            D_MDEN2: begin
                w_mul_a = {2'b0, r_prod[28:0]};
                w_mul_b = ledcrd_pkg::DEN_SCALE;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = {16'b0, w_mul_a} * {31'b0, w_mul_b};

    // mode factor, 8-bit wrap
    assign w_q205    = r_prod[ledcrd_pkg::RECIP_SHIFT +: 8];
    assign w_fac     = r_off + ((r_mode == ledcrd_pkg::MODE_STEPLESS) ? w_q205 : 8'd0);
    assign w_fac_pos = !w_fac[7] && (w_fac != 8'd0);

    assign w_den      = r_prod[38:0];
    assign w_rem_ge   = (r_rem >= {2'b0, r_dsh});
    assign w_quo_next = {r_quo[ledcrd_pkg::DUTY_W-2:0], w_rem_ge};

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE:  if (i_start) n_state = D_Q205;
            D_Q205:  n_state = D_FACT;
            D_FACT:  n_state = w_fac_pos ? D_MNUM : D_DONE;
            D_MNUM:  n_state = D_MDEN1;
            D_MDEN1: n_state = D_MDEN2;
            D_MDEN2: n_state = D_CHK;
            D_CHK: begin
                if ((r_num == '0) || (w_den == '0) || (r_num >= {1'b0, w_den, 14'b0})) begin
                    n_state = D_DONE;
                end else begin
                    n_state = D_DIV;
                end
            end
            D_DIV:   if (r_cnt == 4'd0) n_state = D_DONE;
            D_DONE:  n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (r_state)
            D_IDLE: begin
                r_ma    <= i_req.ma;
                r_shunt <= i_req.shunt;
                r_mode  <= i_req.mode;
                r_off   <= i_req.off;
                r_vmv   <= i_req.vmv;
                r_divr  <= i_req.divr;
            end
            D_FACT: begin
                r_fac <= w_fac[6:0];
                if (!w_fac_pos) r_duty <= '0;
            end
            D_MDEN1: r_num <= {r_prod[37:0], 16'b0};
            D_CHK: begin
                r_rem <= r_num;
                r_dsh <= {w_den, 13'b0};
                r_quo <= '0;
                r_cnt <= 4'd13;
                if (r_num == '0) begin
                    r_duty <= '0;
                end else if (w_den == '0) begin
                    r_duty <= ledcrd_pkg::DUTY_MAX;
                end else if (r_num >= {1'b0, w_den, 14'b0}) begin
                    r_duty <= ledcrd_pkg::DUTY_MAX;
                end
            end
            D_DIV: begin
                if (w_rem_ge) r_rem <= r_rem - {2'b0, r_dsh};
                r_dsh <= {1'b0, r_dsh[51:1]};
                r_quo <= w_quo_next;
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_duty <= (w_quo_next > ledcrd_pkg::DUTY_MAX) ? ledcrd_pkg::DUTY_MAX
                                                                 : w_quo_next;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == D_DONE);
    assign o_rsp.duty = r_duty;

endmodule

/* rtl/led_current_ramp_and_duty.sv */
// ----------------------------------------------------------------------------
// led_current_ramp_and_duty
// Per-tick target clamp, slow ramp, channel/shunt select and PWM duty.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    tdata 56b, tuser 2b (one tick)
//   m_axis    out  m_axis_tvalid/m_axis_tready    tdata 40b (one result)
//   cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_addr 3b, i_cfg_data 16b
//
// A tick with unchanged or zero target skips the duty engine: ramp step, then
// output state. Otherwise the duty engine runs 5 shared-multiplier steps, a
// range check, 14 restoring-divider steps and a done state; a non-positive
// factor ends it after the factor step, a zero or capped quotient after the
// range check. One tick in flight; s_axis_tready is low until its result
// is in the output register. The output register holds one result while the
// next tick is taken. Synchronous active-low reset; no memories.
// ----------------------------------------------------------------------------
module led_current_ramp_and_duty (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // tdata: requested_ma[14:0], output_inhibit[15], thermal_limit_ma[30:16],
    //        mode_offset_pct[38:31], system_mode_set[39], supply_mv[52:40]
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ledcrd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: mode_kind[1:0]
    input  logic [ledcrd_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // tdata: duty_centi_pct[13:0], converter_enable[14], reverse_gate_on[15],
    //        low_shunt_select[16], high_shunt_select[17], applied_ma[32:18],
    //        update_pulse[33]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [ledcrd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ledcrd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [ledcrd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RAMP = 4'b0010,
        S_DUTY = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic [14:0]        req;
        logic               inhibit;
        logic [14:0]        therm;
        ledcrd_pkg::t_mode  mode;
        logic signed [7:0]  off;
        logic               sysm;
        logic [12:0]        vmv;
    } t_tick;

    t_state r_state, n_state;
    t_tick  r_in;

    // config
    logic [14:0] r_turbo;
    logic [14:0] r_aux_max;
    logic [15:0] r_main_shunt;
    logic [15:0] r_aux_shunt;
    logic [15:0] r_divr;

    // control state
    logic [14:0] r_ramp;
    logic        r_slow;
    logic        r_conv_on;
    logic [13:0] r_held_duty;
    logic        r_held_main;
    logic        r_update;
    logic        r_out_valid;
    logic [ledcrd_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [14:0] w_limit;
    logic [14:0] w_tgt0;
    logic [14:0] w_target;
    logic        w_upd;
    logic [15:0] w_diff;
    logic        w_big_jump;
    logic        w_slow_set;
    logic [15:0] w_step;
    logic [15:0] w_next_r;
    logic [14:0] w_ramp_new;
    logic        w_slow_new;
    logic        w_main;
    logic        w_start;
    logic        w_out_load;

    ledcrd_pkg::t_duty_req w_req;
    ledcrd_pkg::t_duty_rsp w_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // target and ramp step
    assign w_limit  = (r_in.therm > r_turbo) ? r_turbo : r_in.therm;
    assign w_tgt0   = r_in.inhibit ? 15'd0 : r_in.req;
    assign w_target = (w_tgt0 > w_limit) ? w_limit : w_tgt0;
    assign w_upd    = (r_ramp != w_target);

    assign w_diff     = {1'b0, w_target} - {1'b0, r_ramp};
    assign w_big_jump = !w_diff[15] && (w_diff > ledcrd_pkg::FAST_JUMP_MA);
    assign w_slow_set = r_slow || w_big_jump;

    always_comb begin
        case (r_in.mode)
            ledcrd_pkg::MODE_BLINK:  w_step = ledcrd_pkg::STEP_STROBE_MA;
            ledcrd_pkg::MODE_BEACON: w_step = ledcrd_pkg::STEP_SOS_MA;
            default:                 w_step = ledcrd_pkg::STEP_OTHER_MA;
        endcase
    end

    assign w_next_r = (r_ramp == 15'd0) ? ledcrd_pkg::RAMP_START_MA : ({1'b0, r_ramp} + w_step);

    always_comb begin
        w_ramp_new = w_target;
        w_slow_new = w_slow_set;
        if (!r_in.sysm && w_slow_set) begin
            if (w_next_r >= {1'b0, w_target}) begin
                w_ramp_new = w_target;
                w_slow_new = 1'b0;
            end else begin
                w_ramp_new = w_next_r[14:0];
                w_slow_new = 1'b1;
            end
        end
    end

    assign w_main  = (w_ramp_new > r_aux_max);
    assign w_start = (r_state == S_RAMP) && w_upd && (w_target != 15'd0);

    assign w_req.ma    = w_ramp_new;
    assign w_req.shunt = w_main ? r_main_shunt : r_aux_shunt;
    assign w_req.mode  = r_in.mode;
    assign w_req.off   = $unsigned(r_in.off);
    assign w_req.vmv   = r_in.vmv;
    assign w_req.divr  = r_divr;

    ledcrd_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_RAMP;
            S_RAMP:  n_state = w_start ? S_DUTY : S_OUT;
            S_DUTY:  if (w_rsp.done) n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_turbo      <= '0;
            r_aux_max    <= '0;
            r_main_shunt <= 16'd1;
            r_aux_shunt  <= 16'd1;
            r_divr       <= 16'd32768;
            r_ramp       <= '0;
            r_slow       <= 1'b0;
            r_conv_on    <= 1'b0;
            r_held_duty  <= '0;
            r_held_main  <= 1'b0;
            r_update     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    ledcrd_pkg::REG_TURBO_LIMIT: r_turbo      <= i_cfg_data[14:0];
                    ledcrd_pkg::REG_AUX_MAX:     r_aux_max    <= i_cfg_data[14:0];
                    ledcrd_pkg::REG_MAIN_SHUNT:  r_main_shunt <= i_cfg_data;
                    ledcrd_pkg::REG_AUX_SHUNT:   r_aux_shunt  <= i_cfg_data;
                    ledcrd_pkg::REG_DIVIDER:     r_divr       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_state == S_RAMP) begin
                r_update <= w_upd;
                if (w_upd) begin
                    if (w_target != 15'd0) begin
                        r_ramp <= w_ramp_new;
                        r_slow <= w_slow_new;
                        if (!r_conv_on) begin
                            r_held_main <= w_main;
                            r_conv_on   <= 1'b1;
                        end
                    end else begin
                        r_ramp      <= '0;
                        r_conv_on   <= 1'b0;
                        r_held_duty <= '0;
                        r_held_main <= 1'b0;
                    end
                end
            end

            if ((r_state == S_DUTY) && w_rsp.done) r_held_duty <= w_rsp.duty;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.req     <= s_axis_tdata[14:0];
            r_in.inhibit <= s_axis_tdata[15];
            r_in.therm   <= s_axis_tdata[30:16];
            r_in.mode    <= ledcrd_pkg::t_mode'(s_axis_tuser[1:0]);
            r_in.off     <= $signed(s_axis_tdata[38:31]);
            r_in.sysm    <= s_axis_tdata[39];
            r_in.vmv     <= s_axis_tdata[52:40];
        end
        if (w_out_load) begin
            r_out_data <= {6'b0, r_update, r_ramp, r_held_main,
                           (r_conv_on && !r_held_main), r_held_main, r_conv_on, r_held_duty};
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_RAMP))
        else $error("accepted tick did not enter ramp step");

    a_done_in_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DUTY))
        else $error("duty engine finished outside duty wait");

    a_on_has_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conv_on |-> (r_ramp != 15'd0))
        else $error("converter on with zero applied current");

    a_off_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_conv_on |-> ((r_ramp == 15'd0) && (r_held_duty == 14'd0) && !r_held_main))
        else $error("converter off but state not cleared");

    a_duty_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_duty <= ledcrd_pkg::DUTY_MAX)
        else $error("held duty above cap");
`endif

endmodule

/* bench/led_current_ramp_and_duty_test.sv */
// ----------------------------------------------------------------------------
// led_current_ramp_and_duty_test
// Checks the current ramp, channel select and PWM duty of the LED driver.
// A directed table covers limits, zero targets, ramp steps per mode and
// offset wrap; random ramp runs then go through five register settings with
// bursty input and a stalling output, each result checked against a model.
// ----------------------------------------------------------------------------
module led_current_ramp_and_duty_test;

    localparam int unsigned RAMP_DIV      = 205;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          LONG_HOLD     = 300;
    localparam int          PHASES        = 5;
    localparam int          PHASE_TICKS   = 125;
    localparam int          DIR_ROWS      = 23;

    typedef struct packed {
        logic [ledcrd_pkg::MA_W-1:0]  req;
        logic                         inh;
        logic [ledcrd_pkg::MA_W-1:0]  therm;
        ledcrd_pkg::t_mode            mode;
        logic [ledcrd_pkg::OFF_W-1:0] off;
        logic                         sysm;
        logic [ledcrd_pkg::VMV_W-1:0] vmv;
    } t_tick;

    // same order as m_axis_tdata[33:0], msb first
    typedef struct packed {
        logic                          upd;
        logic [ledcrd_pkg::MA_W-1:0]   applied;
        logic                          high_sh;
        logic                          low_sh;
        logic                          rev;
        logic                          conv;
        logic [ledcrd_pkg::DUTY_W-1:0] duty;
    } t_drive;

    typedef struct packed {
        t_tick  tk;
        logic   typed;
        t_drive res;
    } t_dir_row;

    localparam t_drive OFF_HOLD = '{1'b0, 15'd0, 1'b0, 1'b0, 1'b0, 1'b0, 14'd0};
    localparam t_drive OFF_UPD  = '{1'b1, 15'd0, 1'b0, 1'b0, 1'b0, 1'b0, 14'd0};

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [ledcrd_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [ledcrd_pkg::IN_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [ledcrd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [ledcrd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [ledcrd_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    led_current_ramp_and_duty dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // model registers and state
    logic [ledcrd_pkg::MA_W-1:0]    cfg_turbo       = '0;
    logic [ledcrd_pkg::MA_W-1:0]    cfg_aux_max     = '0;
    logic [ledcrd_pkg::SHUNT_W-1:0] cfg_main_shunt  = 16'd1;
    logic [ledcrd_pkg::SHUNT_W-1:0] cfg_aux_shunt   = 16'd1;
    logic [ledcrd_pkg::DIVR_W-1:0]  cfg_divider     = 16'd32768;
    logic [ledcrd_pkg::MA_W-1:0]    ramp_ma         = '0;
    logic                           slow_ramp       = 1'b0;
    logic                           conv_on         = 1'b0;
    logic [ledcrd_pkg::DUTY_W-1:0]  duty_held       = '0;
    logic                           main_held       = 1'b0;

    t_drive   pending_drive_q [$];
    t_dir_row dir_rows [DIR_ROWS];

    int n_errors = 0;
    int n_ticks = 0;
    int n_results = 0;
    int n_cfg_writes = 0;
    int n_ramp_steps = 0;
    int n_capped = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit rx_hold_req = 1'b0;

    // random run state: a run holds one target for several ticks
    int                run_left = 0;
    logic [14:0]       run_req, run_therm;
    logic [7:0]        run_off;
    ledcrd_pkg::t_mode run_mode;
    logic              run_sysm;

    function automatic logic [ledcrd_pkg::DUTY_W-1:0] pwm_duty(int unsigned shunt,
                                                               int unsigned ma,
                                                               ledcrd_pkg::t_mode mode,
                                                               logic [7:0] off,
                                                               int unsigned vmv);
        logic [7:0]       f;
        longint unsigned  num, den, q;
        f = off;
        // stepless mode adds ma/205 percent, wrapping in 8 bits
        if (mode == ledcrd_pkg::MODE_STEPLESS)
            f = f + 8'(ma / RAMP_DIV);
        if (f[7] || f == 8'd0)
            return '0;
        num = 64'(ma) * 64'(shunt) * 64'd65536 * 64'(f);
        if (num == 0)
            return '0;
        den = 64'(cfg_divider) * 64'(vmv) * 64'd1000;
        if (den == 0)
            return ledcrd_pkg::DUTY_MAX;
        q = num / den;
        if (q > 64'(ledcrd_pkg::DUTY_MAX)) begin
            n_capped++;
            return ledcrd_pkg::DUTY_MAX;
        end
        return q[ledcrd_pkg::DUTY_W-1:0];
    endfunction

    function automatic t_drive apply_tick(t_tick tk);
        int unsigned limit, target, r;
        logic        main_ch;
        t_drive      d;
        limit  = 32'((tk.therm > cfg_turbo) ? cfg_turbo : tk.therm);
        target = tk.inh ? 32'd0 : 32'(tk.req);
        if (target > limit)
            target = limit;
        d.upd = 1'b0;
        if (target != 32'(ramp_ma)) begin
            d.upd = 1'b1;
            if (target > 0) begin
                if (int'(target) - int'(ramp_ma) > int'(ledcrd_pkg::FAST_JUMP_MA))
                    slow_ramp = 1'b1;
                if (!tk.sysm && slow_ramp) begin
                    r = 32'(ramp_ma);
                    if (r == 0) begin
                        r = 32'(ledcrd_pkg::RAMP_START_MA);
                    end else begin
                        case (tk.mode)
                            ledcrd_pkg::MODE_BLINK:  r += 32'(ledcrd_pkg::STEP_STROBE_MA);
                            ledcrd_pkg::MODE_BEACON: r += 32'(ledcrd_pkg::STEP_SOS_MA);
                            default:                 r += 32'(ledcrd_pkg::STEP_OTHER_MA);
                        endcase
                    end
                    if (r >= target) begin
                        slow_ramp = 1'b0;
                        r = target;
                    end
                    ramp_ma = r[ledcrd_pkg::MA_W-1:0];
                    n_ramp_steps++;
                end else begin
                    ramp_ma = target[ledcrd_pkg::MA_W-1:0];
                end
                main_ch = ramp_ma > cfg_aux_max;
                // pins latch the channel only when the converter turns on
                if (!conv_on) begin
                    main_held = main_ch;
                    conv_on = 1'b1;
                end
                duty_held = pwm_duty(32'(main_ch ? cfg_main_shunt : cfg_aux_shunt),
                                     32'(ramp_ma), tk.mode, tk.off, 32'(tk.vmv));
            end else begin
                conv_on = 1'b0;
                duty_held = '0;
                main_held = 1'b0;
                ramp_ma = '0;
            end
        end
        d.duty    = duty_held;
        d.conv    = conv_on;
        d.rev     = main_held;
        d.low_sh  = conv_on && !main_held;
        d.high_sh = main_held;
        d.applied = ramp_ma;
        return d;
    endfunction

    function automatic t_tick random_tick();
        t_tick tk;
        if (run_left == 0) begin
            run_left = $urandom_range(1, 30);
            case ($urandom_range(0, 9))
                0:       run_req = '0;
                1, 2:    run_req = 15'($urandom_range(1, 6000));
                3:       run_req = 15'd32767;
                default: run_req = 15'($urandom_range(6001, 32767));
            endcase
            run_mode  = ledcrd_pkg::t_mode'($urandom_range(0, 3));
            run_sysm  = ($urandom_range(0, 7) == 0);
            run_therm = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(0, 32767))
                                                    : 15'd32767;
            run_off   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(1, 127));
        end
        run_left--;
        if ($urandom_range(0, 9) == 0) begin
            // noise tick, every field free
            tk.req   = 15'($urandom_range(0, 32767));
            tk.inh   = 1'($urandom_range(0, 1));
            tk.therm = 15'($urandom_range(0, 32767));
            tk.mode  = ledcrd_pkg::t_mode'($urandom_range(0, 3));
            tk.off   = 8'($urandom_range(0, 255));
            tk.sysm  = 1'($urandom_range(0, 1));
        end else begin
            if ($urandom_range(0, 19) == 0)
                run_mode = ledcrd_pkg::t_mode'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
                run_off = 8'($urandom_range(0, 255));
            tk.req   = run_req;
            tk.inh   = ($urandom_range(0, 24) == 0);
            tk.therm = run_therm;
            tk.mode  = run_mode;
            tk.off   = run_off;
            tk.sysm  = run_sysm;
        end
        tk.vmv = 13'($urandom_range(1000, 6000));
        return tk;
    endfunction

    task automatic send_tick(t_tick tk, logic typed, t_drive typed_res);
        int     gap;
        t_drive d;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, tk.vmv, tk.sysm, tk.off, tk.therm, tk.inh, tk.req};
        s_axis_tuser  <= tk.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        d = apply_tick(tk);
        if (typed)
            d = typed_res;
        pending_drive_q.push_back(d);
        n_ticks++;
    endtask

    // stop offering and wait for every pending result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_drive_q.size() != 0);
    endtask

    task automatic load_config(logic [15:0] turbo, logic [15:0] aux_max,
                               logic [15:0] main_shunt, logic [15:0] aux_shunt,
                               logic [15:0] divr);
        ledcrd_pkg::t_reg_idx regs [5];
        logic [15:0]          vals [5];
        int                   i;
        regs = '{ledcrd_pkg::REG_TURBO_LIMIT, ledcrd_pkg::REG_AUX_MAX,
                 ledcrd_pkg::REG_MAIN_SHUNT, ledcrd_pkg::REG_AUX_SHUNT,
                 ledcrd_pkg::REG_DIVIDER};
        vals = '{turbo, aux_max, main_shunt, aux_shunt, divr};
        for (i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (regs[i])
                ledcrd_pkg::REG_TURBO_LIMIT: cfg_turbo      = vals[i][ledcrd_pkg::MA_W-1:0];
                ledcrd_pkg::REG_AUX_MAX:     cfg_aux_max    = vals[i][ledcrd_pkg::MA_W-1:0];
                ledcrd_pkg::REG_MAIN_SHUNT:  cfg_main_shunt = vals[i];
                ledcrd_pkg::REG_AUX_SHUNT:   cfg_aux_shunt  = vals[i];
                ledcrd_pkg::REG_DIVIDER:     cfg_divider    = vals[i];
                default: ;
            endcase
            n_cfg_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: want %0d got %0d",
                                      n_results, name, want, got));
    endtask

    always @(posedge i_clk) begin : result_check
        t_drive got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[33:0];
            if (pending_drive_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          n_results));
            end else begin
                want = pending_drive_q.pop_front();
                check_field("duty", 16'(want.duty), 16'(got.duty));
                check_field("converter_enable", 16'(want.conv), 16'(got.conv));
                check_field("reverse_gate", 16'(want.rev), 16'(got.rev));
                check_field("low_shunt", 16'(want.low_sh), 16'(got.low_sh));
                check_field("high_shunt", 16'(want.high_sh), 16'(got.high_sh));
                check_field("applied_ma", 16'(want.applied), 16'(got.applied));
                check_field("update", 16'(want.upd), 16'(got.upd));
            end
            n_results++;
        end
    end

    // output side: random stall patterns, plus one long hold on request
    initial begin : rx_stall
        int rx_pat, rx_pat_left, rx_hold_left;
        rx_pat = 0;
        rx_pat_left = 0;
        rx_hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_pat_left == 0) begin
                    rx_pat = $urandom_range(0, 2);
                    rx_pat_left = $urandom_range(5, 60);
                end
                rx_pat_left--;
                case (rx_pat)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("no beat for %0d cycles, giving up", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : main_seq
        int i, p, k;
        // offsets: 8'h80 = -128, 8'hFF = -1
        dir_rows = '{
            // reset registers: turbo limit 0 keeps everything off
            '{'{15'd1000,  1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd100, 1'b0, 13'd3300},
              1'b1, OFF_HOLD},
            '{'{15'd3000,  1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd100, 1'b0, 13'd3300},
              1'b0, '0},
            '{'{15'd3000,  1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd100, 1'b0, 13'd3300},
              1'b0, '0},
            // inhibit forces zero target
            '{'{15'd3000,  1'b1, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd100, 1'b0, 13'd3300},
              1'b1, OFF_UPD},
            // big jump: slow ramp from 1500, strobe / SOS / normal / stepless steps
            '{'{15'd20000, 1'b0, 15'd32767, ledcrd_pkg::MODE_BLINK,    8'd50,  1'b0, 13'd3300},
              1'b0, '0},
            '{'{15'd20000, 1'b0, 15'd32767, ledcrd_pkg::MODE_BLINK,    8'd50,  1'b0, 13'd3300},
              1'b0, '0},
            '{'{15'd20000, 1'b0, 15'd32767, ledcrd_pkg::MODE_BEACON,   8'd50,  1'b0, 13'd3300},
              1'b0, '0},
            '{'{15'd20000, 1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd50,  1'b0, 13'd3300},
              1'b0, '0},
            '{'{15'd20000, 1'b0, 15'd32767, ledcrd_pkg::MODE_STEPLESS, 8'd20,  1'b0, 13'd3300},
              1'b0, '0},
            // system mode jumps straight to target, ramp flag left set
            '{'{15'd20000, 1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd50,  1'b1, 13'd3300},
              1'b0, '0},
            '{'{15'd32767, 1'b0, 15'd32767, ledcrd_pkg::MODE_STEPLESS, 8'd127, 1'b1, 13'd6000},
              1'b0, '0},
            // thermal limit zero
            '{'{15'd32767, 1'b0, 15'd0,     ledcrd_pkg::MODE_NORMAL,   8'd127, 1'b0, 13'd6000},
              1'b1, OFF_UPD},
            '{'{15'd0,     1'b0, 15'd0,     ledcrd_pkg::MODE_NORMAL,   8'd127, 1'b0, 13'd6000},
              1'b1, OFF_HOLD},
            // stale ramp flag restarts at 1500; negative and zero factors
            '{'{15'd5000,  1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'h80,  1'b0, 13'd1000},
              1'b0, '0},
            '{'{15'd5000,  1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd0,   1'b0, 13'd1000},
              1'b0, '0},
            // thermal clamp below the ramp: step overshoots, takes the target
            '{'{15'd32767, 1'b0, 15'd1000,  ledcrd_pkg::MODE_NORMAL,   8'd127, 1'b0, 13'd1000},
              1'b0, '0},
            // max current at min supply saturates the duty
            '{'{15'd32767, 1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd127, 1'b1, 13'd1000},
              1'b0, '0},
            // stepless wrap: -1 becomes positive, -128 stays negative
            '{'{15'd8000,  1'b0, 15'd32767, ledcrd_pkg::MODE_STEPLESS, 8'hFF,  1'b1, 13'd4096},
              1'b0, '0},
            '{'{15'd300,   1'b0, 15'd32767, ledcrd_pkg::MODE_STEPLESS, 8'h80,  1'b0, 13'd4096},
              1'b0, '0},
            '{'{15'd1,     1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd1,   1'b0, 13'd6000},
              1'b0, '0},
            '{'{15'd32767, 1'b1, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd1,   1'b0, 13'd6000},
              1'b1, OFF_UPD},
            // aux channel boundary, then main while pins stay latched on aux
            '{'{15'd2000,  1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd64,  1'b0, 13'd3300},
              1'b0, '0},
            '{'{15'd2001,  1'b0, 15'd32767, ledcrd_pkg::MODE_NORMAL,   8'd64,  1'b0, 13'd3300},
              1'b0, '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            if (i == 1) begin
                drain_results();
                load_config(16'd32767, 16'd2000, 16'd5000, 16'd20000, 16'd32768);
            end
            send_tick(dir_rows[i].tk, dir_rows[i].typed, dir_rows[i].res);
        end

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: load_config(16'd32767, 16'd0, 16'd1, 16'd1, 16'd1);
                1: load_config(16'd9000, 16'd32767, 16'd65535, 16'd65535, 16'd65535);
                2: load_config(16'($urandom_range(2000, 32767)), 16'($urandom_range(0, 32767)),
                               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                               16'($urandom_range(1, 65535)));
                default: load_config(16'($urandom_range(2000, 32767)),
                                     16'($urandom_range(0, 32767)),
                                     16'($urandom_range(100, 5000)),
                                     16'($urandom_range(100, 5000)),
                                     16'($urandom_range(16384, 65535)));
            endcase
            for (k = 0; k < PHASE_TICKS; k++) begin
                if (p == 2 && k == 40)
                    rx_hold_req = 1'b1;
                send_tick(random_tick(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (30) @(posedge i_clk);

        $display("%0d ticks (%0d from the table) and %0d results over %0d register writes",
                 n_ticks, DIR_ROWS, n_results, n_cfg_writes);
        $display("%0d slow ramp steps, %0d saturated duties, %0d mismatches",
                 n_ramp_steps, n_capped, n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* led_current_ramp_and_duty.f */
rtl/ledcrd_pkg.sv
rtl/ledcrd_duty.sv
rtl/led_current_ramp_and_duty.sv
bench/led_current_ramp_and_duty_test.sv
